// ===== rtl/multi_channel_pwm_width_capture_core_macros.svh =====
// Assertion helpers shared by the capture core.
// Sampled on aclk and disabled while aresetn is low.
`ifndef MULTI_CHANNEL_PWM_WIDTH_CAPTURE_CORE_MACROS_SVH
`define MULTI_CHANNEL_PWM_WIDTH_CAPTURE_CORE_MACROS_SVH

// Property holds in the same cycle.
`define MPWC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MPWC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mpwc_pkg.sv =====
package mpwc_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int CH_W             = 3;
    localparam int TIME_W           = 32;
    localparam int DEB_W            = 16;
    localparam int WIDTH_W          = 25;
    localparam int IN_DATA_W        = 40;
    localparam int OUT_DATA_W       = 32;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd200;

    // width = diff / 200 = (diff >> 3) / 25
    localparam int TICKS_PER_US = 200;
    localparam int PRE_SHIFT    = 3;
    localparam int DIV_ODD      = TICKS_PER_US / (1 << PRE_SHIFT);
    localparam int X_W          = TIME_W - PRE_SHIFT;
    localparam int RECIP_W      = 28;
    localparam int PROD_W       = X_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL = (64'd1 << TIME_W) / DIV_ODD;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_US = 25'd21474836;

    typedef enum logic [2:0] {
        ST_WAITING    = 3'b001,
        ST_DEBOUNCING = 3'b010,
        ST_CONFIRM    = 3'b100
    } phase_state_t;

    typedef struct packed {
        phase_state_t      state;
        logic              stable;
        logic              first;
        logic [TIME_W-1:0] edge_stamp;
        logic [TIME_W-1:0] prev_stamp;
    } chan_t;

    localparam chan_t CHAN_RESET = '{
        state:      ST_WAITING,
        stable:     1'b0,
        first:      1'b1,
        edge_stamp: '0,
        prev_stamp: '0
    };

    // Wrapped difference is one tick short of a true wrap.
    function automatic logic [TIME_W-1:0] tick_diff(input logic [TIME_W-1:0] later,
                                                    input logic [TIME_W-1:0] earlier);
        logic [TIME_W-1:0] d;
        d = later - earlier;
        if (later < earlier) begin
            d = later + ~earlier;
        end
        return d;
    endfunction

endpackage

// ===== rtl/multi_channel_pwm_width_capture_core.sv =====
// A beat passes stage 1, stage 2, stage 3 and the output register before m_tvalid.
// Throughput: one beat per cycle unless m_tready stalls it; each channel's record is
// read, modified and written back via a registered memory that forwards the last write.
// Reset (aresetn low, synchronous): per-channel valid bits and all pipeline valids
// clear, debounce_ticks returns to 200; unwritten channels read as reset state.
`include "multi_channel_pwm_width_capture_core_macros.svh"

module multi_channel_pwm_width_capture_core #(
    parameter int NUM_CHANNELS = mpwc_pkg::NUM_CHANNELS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mpwc_pkg::DEB_W-1:0]       cfg_data,    // debounce_ticks
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mpwc_pkg::IN_DATA_W-1:0]   s_tdata,     // channel, pin_level, time_count
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mpwc_pkg::OUT_DATA_W-1:0]  m_tdata,     // out_channel, width_us
    output logic                             m_tuser      // phase_was_high
);
    import mpwc_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int EXT_W = IDX_W + CH_W;

    // input unpack
    logic [CH_W-1:0]   in_ch;
    logic              in_pin;
    logic [TIME_W-1:0] in_time;
    logic [EXT_W-1:0]  in_ch_ext;
    logic [IDX_W-1:0]  in_idx;
    logic              in_range;
    logic              accept;

    assign in_ch     = s_tdata[CH_W-1:0];
    assign in_pin    = s_tdata[CH_W];
    assign in_time   = s_tdata[CH_W+TIME_W:CH_W+1];
    assign in_ch_ext = {{IDX_W{1'b0}}, in_ch};
    assign in_idx    = in_ch_ext[IDX_W-1:0];
    assign in_range  = in_ch_ext < EXT_W'(NUM_CHANNELS);

    logic [DEB_W-1:0] deb_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg <= DEBOUNCE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            deb_reg <= cfg_data;
        end
    end

    // stage enables
    logic out_en, s3_en, s2_en, s1_en;
    logic m_valid_reg, s3_valid_reg, s2_valid_reg, s1_valid_reg;

    assign out_en   = !m_valid_reg || m_tready;
    assign s3_en    = !s3_valid_reg || out_en;
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign s_tready = s1_en;
    assign accept   = s_tvalid && s_tready;

    // channel record memory
    chan_t                   mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] vld_reg;
    chan_t                   rd_reg;
    logic                    rdv_reg;
    logic                    wr_en;
    chan_t                   nxt;

    logic              s1_range_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic [CH_W-1:0]   s1_ch_reg;
    logic              s1_pin_reg;
    logic [TIME_W-1:0] s1_time_reg;

    logic              fwd_valid_reg;
    logic [IDX_W-1:0]  fwd_idx_reg;
    chan_t             fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (accept && in_range) begin
            rd_reg  <= mem[in_idx];
            rdv_reg <= vld_reg[in_idx];
        end
        if (wr_en) begin
            mem[s1_idx_reg] <= nxt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            fwd_valid_reg <= 1'b0;
        end else if (wr_en) begin
            vld_reg[s1_idx_reg] <= 1'b1;
            fwd_valid_reg       <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fwd_idx_reg  <= s1_idx_reg;
            fwd_data_reg <= nxt;
        end
    end

    // stage 1: modify
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_en) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_range_reg <= in_range;
            s1_idx_reg   <= in_idx;
            s1_ch_reg    <= in_ch;
            s1_pin_reg   <= in_pin;
            s1_time_reg  <= in_time;
        end
    end

    chan_t             cur;
    logic              s1_res;
    logic [TIME_W-1:0] hold_ticks;
    logic [TIME_W-1:0] phase_ticks;

    always_comb begin
        if (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg)) begin
            cur = fwd_data_reg;
        end else if (rdv_reg) begin
            cur = rd_reg;
        end else begin
            cur = CHAN_RESET;
        end
    end

    assign hold_ticks  = tick_diff(s1_time_reg, cur.edge_stamp);
    assign phase_ticks = cur.first ? '0 : tick_diff(cur.edge_stamp, cur.prev_stamp);

    always_comb begin
        nxt    = cur;
        s1_res = 1'b0;
        unique case (cur.state)
            ST_DEBOUNCING: begin
                if (s1_pin_reg != cur.stable) begin
                    if (TIME_W'(deb_reg) <= hold_ticks) begin
                        nxt.state = ST_CONFIRM;
                    end
                end else begin
                    nxt.state = ST_WAITING;
                end
            end
            ST_CONFIRM: begin
                s1_res         = 1'b1;
                nxt.first      = 1'b0;
                nxt.prev_stamp = cur.edge_stamp;
                nxt.stable     = s1_pin_reg;
                nxt.state      = ST_WAITING;
            end
            default: begin
                if (s1_pin_reg != cur.stable) begin
                    nxt.edge_stamp = s1_time_reg;
                    nxt.state      = ST_DEBOUNCING;
                end
            end
        endcase
    end

    assign wr_en = s1_valid_reg && s1_range_reg && s2_en;

    // stage 2: reciprocal multiply operand
    logic [CH_W-1:0] s2_ch_reg;
    logic            s2_high_reg;
    logic [X_W-1:0]  s2_x_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_en) begin
            s2_valid_reg <= s1_valid_reg && s1_range_reg && s1_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_en) begin
            s2_ch_reg   <= s1_ch_reg;
            s2_high_reg <= cur.stable;
            s2_x_reg    <= phase_ticks[TIME_W-1:PRE_SHIFT];
        end
    end

    // stage 3: product, then quotient correction
    logic [CH_W-1:0]   s3_ch_reg;
    logic              s3_high_reg;
    logic [X_W-1:0]    s3_x_reg;
    logic [PROD_W-1:0] s3_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_en) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_en) begin
            s3_ch_reg   <= s2_ch_reg;
            s3_high_reg <= s2_high_reg;
            s3_x_reg    <= s2_x_reg;
            s3_prod_reg <= PROD_W'(s2_x_reg) * PROD_W'(RECIP);
        end
    end

    logic [WIDTH_W-1:0] q0;
    logic [X_W:0]       q0_mul;
    logic [X_W:0]       rem;
    logic [WIDTH_W-1:0] quot;

    assign q0     = s3_prod_reg[PROD_W-1:TIME_W];
    assign q0_mul = ((X_W+1)'(q0) << 4) + ((X_W+1)'(q0) << 3) + (X_W+1)'(q0);
    assign rem    = (X_W+1)'(s3_x_reg) - q0_mul;
    assign quot   = (rem >= (X_W+1)'(DIV_ODD)) ? q0 + 1'b1 : q0;

    // output register
    logic [CH_W-1:0]    m_ch_reg;
    logic               m_high_reg;
    logic [WIDTH_W-1:0] m_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            m_ch_reg    <= s3_ch_reg;
            m_high_reg  <= s3_high_reg;
            m_width_reg <= quot;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-CH_W-WIDTH_W){1'b0}}, m_width_reg, m_ch_reg};
    assign m_tuser  = m_high_reg;

    `MPWC_ASSERT(a_out_ch_range, !m_valid_reg || (m_ch_reg < NUM_CHANNELS), "channel out of range")
    `MPWC_ASSERT(a_width_bound, !m_valid_reg || (m_width_reg <= MAX_WIDTH_US), "width over bound")
    `MPWC_ASSERT(a_quot_fix, !s3_valid_reg || (rem < (X_W+1)'(2 * DIV_ODD)), "quotient off")
    `MPWC_ASSERT_NEXT(a_s1_hold, !s1_en, s1_valid_reg && $stable(s1_idx_reg), "held item moved")
    `MPWC_ASSERT(a_no_write_out_of_range, !wr_en || (s1_ch_reg < NUM_CHANNELS), "stray write")

endmodule

// ===== tb/multi_channel_pwm_width_capture_core_tb.sv =====
module multi_channel_pwm_width_capture_core_tb;
    import mpwc_pkg::*;

    localparam int NCH           = NUM_CHANNELS_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_BEATS   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [TIME_W-1:0] tcount;
        logic              pin;
        logic [CH_W-1:0]   ch;
    } visit_t;

    typedef struct packed {
        logic [CH_W-1:0]    ch;
        logic               high;
        logic [WIDTH_W-1:0] width_us;
    } phase_t;

    typedef struct {
        visit_t v;
        bit     typed;
        phase_t r;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [DEB_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;  // channel, pin_level, time_count
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // out_channel, width_us
    logic                  m_tuser;         // phase_was_high

    multi_channel_pwm_width_capture_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    phase_state_t      ch_state  [NCH];
    logic              ch_stable [NCH];
    logic              ch_first  [NCH];
    logic [TIME_W-1:0] ch_stamp  [NCH];
    logic [TIME_W-1:0] ch_prev   [NCH];
    logic [DEB_W-1:0]  debounce;

    logic [TIME_W-1:0] trk_time  [NCH];
    logic              trk_level [NCH];

    phase_t   pending_phases [$];
    dir_row_t dir_rows [$];
    int       mismatches = 0;
    int       cycles     = 0;
    int       burst_left = 0;
    bit       hold_req   = 1'b0;

    // wrapped span is one tick short of a true wrap
    function automatic logic [TIME_W-1:0] span(input logic [TIME_W-1:0] later,
                                               input logic [TIME_W-1:0] earlier);
        if (later >= earlier) begin
            return later - earlier;
        end
        return 32'hFFFF_FFFF - earlier + later;
    endfunction

    function automatic void reset_capture();
        for (int c = 0; c < NCH; c++) begin
            ch_state[c]  = ST_WAITING;
            ch_stable[c] = 1'b0;
            ch_first[c]  = 1'b1;
            ch_stamp[c]  = '0;
            ch_prev[c]   = '0;
        end
        debounce = DEBOUNCE_RESET;
    endfunction

    function automatic bit capture_visit(input visit_t v, output phase_t r);
        logic [TIME_W-1:0] w;
        r = '0;
        case (ch_state[v.ch])
            ST_DEBOUNCING: begin
                if (v.pin != ch_stable[v.ch]) begin
                    if (span(v.tcount, ch_stamp[v.ch]) >= TIME_W'(debounce))
                        ch_state[v.ch] = ST_CONFIRM;
                end else begin
                    ch_state[v.ch] = ST_WAITING;
                end
            end
            ST_CONFIRM: begin
                w = ch_first[v.ch] ? '0 : span(ch_stamp[v.ch], ch_prev[v.ch]) / TICKS_PER_US;
                ch_first[v.ch]  = 1'b0;
                ch_prev[v.ch]   = ch_stamp[v.ch];
                r.ch            = v.ch;
                r.high          = ch_stable[v.ch];
                r.width_us      = w[WIDTH_W-1:0];
                ch_stable[v.ch] = v.pin;
                ch_state[v.ch]  = ST_WAITING;
                return 1'b1;
            end
            default: begin
                if (v.pin != ch_stable[v.ch]) begin
                    ch_stamp[v.ch] = v.tcount;
                    ch_state[v.ch] = ST_DEBOUNCING;
                end
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void add_row(input logic [CH_W-1:0] ch, input logic pin,
                                    input logic [TIME_W-1:0] tc, input bit typed = 1'b0,
                                    input logic high = 1'b0,
                                    input logic [WIDTH_W-1:0] w = '0);
        dir_row_t row;
        row.v.ch        = ch;
        row.v.pin       = pin;
        row.v.tcount    = tc;
        row.typed       = typed;
        row.r.ch        = ch;
        row.r.high      = high;
        row.r.width_us  = w;
        dir_rows.push_back(row);
    endfunction

    task automatic send_visit(input visit_t v, input bit typed, input phase_t typed_r);
        phase_t r;
        bit     has;
        s_tdata  <= IN_DATA_W'(v);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        has = capture_visit(v, r);
        if (typed)
            pending_phases.push_back(typed_r);
        else if (has)
            pending_phases.push_back(r);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
        end
    endtask

    task automatic random_visit();
        int                p;
        logic [TIME_W-1:0] delta;
        visit_t            v;
        v.ch = CH_W'($urandom_range(0, NCH - 1));
        p    = $urandom_range(0, 99);
        if (p < 8) begin
            v.pin    = 1'($urandom_range(0, 1));
            v.tcount = $urandom;
        end else begin
            if (p < 26)
                trk_level[v.ch] = ~trk_level[v.ch];
            p = $urandom_range(0, 99);
            if (p < 55)
                delta = $urandom_range(0, 2 * int'(debounce) + 10);
            else if (p < 85)
                delta = $urandom_range(0, 2000000);
            else if (p < 95)
                delta = $urandom;
            else
                delta = '0;
            trk_time[v.ch] = trk_time[v.ch] + delta;
            v.tcount = trk_time[v.ch];
            v.pin    = trk_level[v.ch] ^ ($urandom_range(0, 9) == 0);
        end
        send_visit(v, 1'b0, '0);
    endtask

    // let in-flight beats with no result clear the pipe too
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_phases.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_debounce(input logic [DEB_W-1:0] val);
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        debounce = val;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [DEB_W-1:0] settings [6];
        reset_capture();

        add_row(0, 1, 100);
        add_row(0, 1, 300);
        add_row(0, 1, 301, 1, 0, 0);
        add_row(0, 0, 1000);
        add_row(0, 1, 1100);                    // bounce back, edge dropped
        add_row(0, 0, 2000);
        add_row(0, 0, 2199);
        add_row(0, 0, 2200);
        add_row(0, 0, 2201, 1, 1, 9);
        add_row(7, 1, 32'hFFFF_FF00);
        add_row(7, 1, 32'h0000_0010);           // debounce across timer wrap
        add_row(7, 1, 32'h0000_0020, 1, 0, 0);
        add_row(7, 0, 32'hFFFF_FFF0);
        add_row(7, 0, 32'hFFFF_FFFF);
        add_row(7, 0, 32'h0000_00C8);
        add_row(7, 0, 32'h0000_0100, 1, 1, 1);
        add_row(3, 1, 32'h0000_0000);
        add_row(3, 1, 32'h0000_00C8);
        add_row(3, 1, 32'h0000_00C9, 1, 0, 0);
        add_row(3, 0, 32'hFFFF_FFFF);
        add_row(3, 0, 32'h0000_00C8);
        add_row(3, 0, 32'h0000_00D0, 1, 1, MAX_WIDTH_US);
        add_row(3, 1, 32'h0000_1000);
        add_row(3, 1, 32'h0000_2000);
        add_row(3, 0, 32'h0000_2001, 1, 0, 20); // stamp earlier than previous

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_visit(dir_rows[i].v, dir_rows[i].typed, dir_rows[i].r);

        for (int c = 0; c < NCH; c++) begin
            trk_time[c]  = $urandom;
            trk_level[c] = 1'($urandom_range(0, 1));
        end

        settings = '{16'd0, 16'hFFFF, 16'd1, DEB_W'($urandom), 16'd200,
                     DEB_W'($urandom_range(2, 50))};
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_debounce(settings[ph]);
            if (ph == 3)
                hold_req <= 1'b1;
            repeat (PHASE_BEATS) random_visit();
        end
        drain();

        if (mismatches == 0 && pending_phases.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        int duty;
        int slot;
        int hold_left;
        bit hold_done;
        duty      = 100;
        slot      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (slot == 0) begin
                    case ($urandom_range(0, 3))
                        0: duty = 100;
                        1: duty = 80;
                        2: duty = 50;
                        default: duty = 15;
                    endcase
                    slot = $urandom_range(16, 96);
                end
                slot--;
                m_tready <= ($urandom_range(1, 100) <= duty);
            end
        end
    end

    always @(posedge aclk) begin
        phase_t want;
        phase_t got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_phases.size());
            $display("Test completed with failures");
            $finish;
        end else if (aresetn && m_tvalid && m_tready) begin
            got.ch       = m_tdata[CH_W-1:0];
            got.high     = m_tuser;
            got.width_us = m_tdata[CH_W +: WIDTH_W];
            if (pending_phases.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: ch %0d high %0d width %0d",
                             got.ch, got.high, got.width_us);
            end else begin
                want = pending_phases.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp ch/high/width %0d/%0d/%0d, got %0d/%0d/%0d",
                                 want.ch, want.high, want.width_us,
                                 got.ch, got.high, got.width_us);
                end
            end
        end
    end

endmodule
